/* src/assert_macros.svh */
// assertion helpers, sampled on clk, off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/tcse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tcse_pkg;
	localparam int BUF_DEPTH   = 1024;
	localparam int ADDR_W      = $clog2(BUF_DEPTH);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int REL_W       = ADDR_W + 2;
	localparam int ABS_W       = REL_W + 1;
	localparam int MAX_PATTERN = 8;
	localparam int SET_SIZE    = 4;
	localparam int CMD_W       = 4;
	localparam int PLEN_W      = 4;
	localparam int OFF_W       = 10;
	localparam int CSIZE_W     = 3;
	localparam int POS_W       = 12;
	localparam int STAT_W      = 2;

	localparam logic [OFF_W-1:0] SCAN_LIMIT_RST = 10'd1000;

	localparam logic [7:0] CH_NUL           = 8'h00;
	localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
	localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
	localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD        = 4'd0,
		CMD_CLEAR       = 4'd1,
		CMD_FIND_START  = 4'd2,
		CMD_FIND_END    = 4'd3,
		CMD_NTH         = 4'd4,
		CMD_FIRST_TWO   = 4'd5,
		CMD_GOTO_START  = 4'd6,
		CMD_GOTO_END    = 4'd7,
		CMD_STARTS_WITH = 4'd8,
		CMD_FIRST_OF    = 4'd9,
		CMD_BLOCK_END   = 4'd10,
		CMD_LAST_BEFORE = 4'd11
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_NOT_FOUND  = 2'd1,
		STAT_UNBALANCED = 2'd2,
		STAT_LIMIT      = 2'd3
	} stat_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic [7:0]              found_char;
		logic                    is_match;
		logic [STAT_W-1:0]       status;
	} res_t;
endpackage
`default_nettype wire

/* src/tcse_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface tcse_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [tcse_pkg::CMD_W-1:0]         command;
	logic [7:0]                         data_byte;
	logic [7:0]                         stop_char;
	logic [8*tcse_pkg::MAX_PATTERN-1:0] pattern;
	logic [tcse_pkg::PLEN_W-1:0]        pattern_len;
	logic [tcse_pkg::OFF_W-1:0]         start_offset;
	logic [tcse_pkg::OFF_W-1:0]         repeat_or_extra;
	logic                               advance;
	logic [8*tcse_pkg::SET_SIZE-1:0]    char_set;
	logic [tcse_pkg::CSIZE_W-1:0]       char_set_size;
	modport source (output valid, command, data_byte, stop_char, pattern, pattern_len,
		start_offset, repeat_or_extra, advance, char_set, char_set_size, input ready);
	modport sink (input valid, command, data_byte, stop_char, pattern, pattern_len,
		start_offset, repeat_or_extra, advance, char_set, char_set_size, output ready);
endinterface

interface tcse_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [tcse_pkg::POS_W-1:0]  position;
	logic [7:0]                         found_char;
	logic                               is_match;
	logic [tcse_pkg::STAT_W-1:0]        status;
	logic                               last_of_run;
	modport source (output valid, position, found_char, is_match, status, last_of_run,
		input ready);
	modport sink (input valid, position, found_char, is_match, status, last_of_run,
		output ready);
endinterface

interface tcse_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tcse_pkg::OFF_W-1:0]  scan_limit;
	modport source (output valid, scan_limit, input ready);
	modport sink (input valid, scan_limit, output ready);
endinterface
`default_nettype wire

/* src/text_cursor_search_engine.sv */
// channel | dir | payload
// cmd     | in  | command, data_byte, stop_char, pattern, pattern_len, start_offset,
//         |     | repeat_or_extra, advance, char_set, char_set_size
// res     | out | position, found_char, is_match, status, last_of_run
// cfg     | in  | scan_limit
//
// load, clear and unknown requests are handled in the idle state and give no result
// scans walk the text one byte per cycle through the single read port of the
// text memory, then pass through the registered read and the result handoff
// first two gives two results
// reset empties the text and homes the cursor; text bytes are not cleared
// a waiting result in the output register stalls only the handoff of the next one
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module text_cursor_search_engine (
	input  logic       clk,
	input  logic       arst_n,
	tcse_cmd_if.sink   cmd,
	tcse_res_if.source res,
	tcse_cfg_if.sink   cfg
);
	import tcse_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
	localparam int DEPTH_W = LEN_W;

	// text memory, one write and one registered read port
	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] mem_q;

	state_t state_q;
	logic [LEN_W-1:0]  text_len_q;
	logic [ADDR_W-1:0] cursor_q;
	logic [OFF_W-1:0]  limit_q;

	// latched request fields
	logic [CMD_W-1:0]           cmd_q;
	logic [7:0]                 dbyte_q;
	logic [7:0]                 stop_q;
	logic [8*MAX_PATTERN-1:0]   pat_q;
	logic [PLEN_W-1:0]          plen_q;
	logic [OFF_W-1:0]           rep_q;
	logic                       adv_q;
	logic [8*SET_SIZE-1:0]      cset_q;
	logic [CSIZE_W-1:0]         csize_q;

	// read issue and the byte returning from memory
	logic [REL_W-1:0] rd_rel_q;
	logic [ABS_W-1:0] rd_abs;
	logic             v_s1;
	logic [REL_W-1:0] rel_s1;
	logic             beyond_s1;

	// scan working state
	logic [7:0]         win_q [MAX_PATTERN];
	logic [FILL_W-1:0]  fill_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [OFF_W-1:0]   cnt_q;
	logic               first_q;
	logic [REL_W-1:0]   idx1_q;
	logic               loc_ok_q;
	logic [REL_W-1:0]   loc_q;

	// results waiting for the output register
	res_t res_a_q, res_b_q;
	logic two_q;

	logic out_v_q;
	res_t out_q;
	logic out_last_q;

	logic cmd_acc;
	logic out_free;

	// per-byte evaluation
	logic [7:0]         c;
	logic [7:0]         win_nx [MAX_PATTERN];
	logic               pat_hit;
	logic               fill_ok;
	logic               set_hit;
	logic [REL_W-1:0]   s_rel;
	logic [REL_W-1:0]   end_rel;
	logic               fin;
	logic               two;
	res_t               ra, rb;
	logic               cur_wr;
	logic [ABS_W-1:0]   cur_sum;
	logic [ADDR_W-1:0]  cur_new;
	logic [DEPTH_W-1:0] depth_nx;
	logic [OFF_W-1:0]   cnt_nx;
	logic               first_nx;
	logic [REL_W-1:0]   idx1_nx;
	logic               loc_ok_nx;
	logic [REL_W-1:0]   loc_nx;

	// clamp a cursor move to the text end and the last buffer slot
	function automatic logic [ADDR_W-1:0] sat_cursor(input logic [ABS_W-1:0] v,
			input logic [LEN_W-1:0] len);
		logic [ABS_W-1:0] t;
		t = v;
		if (t > ABS_W'(len)) t = ABS_W'(len);
		if (t > ABS_W'(BUF_DEPTH - 1)) t = ABS_W'(BUF_DEPTH - 1);
		return t[ADDR_W-1:0];
	endfunction

	function automatic res_t mk_res(input logic [REL_W-1:0] pos, input logic [7:0] fc,
			input logic m, input stat_t st);
		res_t r;
		r.position   = POS_W'(signed'(pos));
		r.found_char = fc;
		r.is_match   = m;
		r.status     = st;
		return r;
	endfunction

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign out_free  = !out_v_q || res.ready;

	assign rd_abs = ABS_W'(cursor_q) + ABS_W'(rd_rel_q);

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd_acc && cmd.command == CMD_LOAD && text_len_q < LEN_W'(BUF_DEPTH)) begin
			mem[text_len_q[ADDR_W-1:0]] <= cmd.data_byte;
		end
		mem_q <= mem[rd_abs[ADDR_W-1:0]];
	end

	// the returning byte, zero past the text end
	assign c       = beyond_s1 ? CH_NUL : mem_q;
	assign s_rel   = rel_s1 + REL_W'(1) - REL_W'(plen_q);
	assign end_rel = rel_s1 + REL_W'(1);
	assign fill_ok = (FILL_W'(fill_q) >= FILL_W'(plen_q - PLEN_W'(1)));

	// window of recent bytes, newest at slot 0
	always_comb begin
		win_nx[0] = c;
		for (int i = 1; i < MAX_PATTERN; i++) win_nx[i] = win_q[i-1];
	end

	// pattern byte j sits at window slot plen-1-j
	always_comb begin
		logic [PLEN_W-1:0] j;
		pat_hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			j = plen_q - PLEN_W'(1) - PLEN_W'(i);
			if (PLEN_W'(i) < plen_q && win_nx[i] != pat_q[8*j[2:0] +: 8]) pat_hit = 1'b0;
		end
	end

	always_comb begin
		set_hit = 1'b0;
		for (int k = 0; k < SET_SIZE; k++) begin
			if (CSIZE_W'(k) < csize_q && c == cset_q[8*k +: 8]) set_hit = 1'b1;
		end
	end

	assign cur_new = sat_cursor(cur_sum, text_len_q);

	// decision on one byte of the scan
	always_comb begin
		logic is_open, is_close;
		is_open   = (c == CH_OPEN_BRACE) || (c == CH_OPEN_BRACKET);
		is_close  = (c == CH_CLOSE_BRACE) || (c == CH_CLOSE_BRACKET);
		fin       = 1'b0;
		two       = 1'b0;
		ra        = mk_res('1, CH_NUL, 1'b0, STAT_NOT_FOUND);
		rb        = mk_res('1, CH_NUL, 1'b0, STAT_NOT_FOUND);
		cur_wr    = 1'b0;
		cur_sum   = ABS_W'(cursor_q);
		depth_nx  = depth_q;
		cnt_nx    = cnt_q;
		first_nx  = first_q;
		idx1_nx   = idx1_q;
		loc_ok_nx = loc_ok_q;
		loc_nx    = loc_q;
		if (state_q == ST_SCAN && v_s1) begin
			unique case (cmd_q)
				CMD_FIND_START, CMD_FIND_END: begin
					if (c == CH_NUL) begin
						fin = 1'b1;
					end else if (fill_ok && pat_hit) begin
						fin = 1'b1;
						ra  = mk_res((cmd_q == CMD_FIND_END) ? end_rel : s_rel,
							CH_NUL, 1'b0, STAT_OK);
					end
				end
				CMD_NTH: begin
					if (c == CH_NUL) begin
						fin = 1'b1;
					end else if (fill_ok && pat_hit) begin
						if (cnt_q + OFF_W'(1) == rep_q) begin
							fin = 1'b1;
							ra  = mk_res(s_rel, CH_NUL, 1'b0, STAT_OK);
						end else begin
							cnt_nx = cnt_q + OFF_W'(1);
						end
					end
				end
				CMD_FIRST_TWO: begin
					if (c == CH_NUL) begin
						fin = 1'b1;
						two = 1'b1;
						if (first_q) ra = mk_res(idx1_q, CH_NUL, 1'b0, STAT_OK);
					end else if (fill_ok && pat_hit) begin
						if (!first_q) begin
							first_nx = 1'b1;
							idx1_nx  = s_rel;
						end else begin
							fin = 1'b1;
							two = 1'b1;
							ra  = mk_res(idx1_q, CH_NUL, 1'b0, STAT_OK);
							rb  = mk_res(s_rel, CH_NUL, 1'b0, STAT_OK);
						end
					end
				end
				CMD_GOTO_START, CMD_GOTO_END: begin
					if (c == CH_NUL) begin
						fin     = 1'b1;
						cur_wr  = 1'b1;
						cur_sum = ABS_W'(cursor_q) + ABS_W'(rel_s1);
					end else if (fill_ok && pat_hit) begin
						fin     = 1'b1;
						cur_wr  = 1'b1;
						cur_sum = (cmd_q == CMD_GOTO_END)
							? ABS_W'(cursor_q) + ABS_W'(end_rel) + ABS_W'(rep_q)
							: ABS_W'(cursor_q) + ABS_W'(s_rel);
						ra = mk_res(REL_W'(cur_new) - REL_W'(cursor_q), CH_NUL, 1'b0,
							STAT_OK);
					end
				end
				CMD_STARTS_WITH: begin
					if (c == CH_NUL) begin
						fin = 1'b1;
						ra  = mk_res('0, CH_NUL, 1'b0, STAT_NOT_FOUND);
					end else if (fill_ok) begin
						fin = 1'b1;
						ra  = mk_res('0, CH_NUL, pat_hit, pat_hit ? STAT_OK : STAT_NOT_FOUND);
						if (pat_hit && adv_q) begin
							cur_wr  = 1'b1;
							cur_sum = ABS_W'(cursor_q) + ABS_W'(plen_q);
						end
					end
				end
				CMD_FIRST_OF: begin
					if (rel_s1 == REL_W'(limit_q)) begin
						fin = 1'b1;
						ra  = mk_res(REL_W'(limit_q), CH_NUL, 1'b0, STAT_LIMIT);
					end else if (set_hit) begin
						fin = 1'b1;
						ra  = mk_res(rel_s1, c, 1'b0, STAT_OK);
						if (adv_q) begin
							cur_wr  = 1'b1;
							cur_sum = ABS_W'(cursor_q) + ABS_W'(rel_s1);
						end
					end else if (c == CH_NUL) begin
						fin = 1'b1;
					end
				end
				CMD_BLOCK_END: begin
					if (c == CH_NUL) begin
						fin = 1'b1;
					end else if (is_open) begin
						depth_nx = depth_q + DEPTH_W'(1);
					end else if (is_close) begin
						if (depth_q == '0) begin
							fin = 1'b1;
							ra  = mk_res('1, CH_NUL, 1'b0, STAT_UNBALANCED);
						end else begin
							depth_nx = depth_q - DEPTH_W'(1);
							if (depth_q == DEPTH_W'(1)) begin
								fin = 1'b1;
								if (adv_q) begin
									cur_wr  = 1'b1;
									cur_sum = ABS_W'(cursor_q) + ABS_W'(end_rel);
									ra      = mk_res('0, CH_NUL, 1'b0, STAT_OK);
								end else begin
									ra = mk_res(end_rel, CH_NUL, 1'b0, STAT_OK);
								end
							end
						end
					end
				end
				CMD_LAST_BEFORE: begin
					if (c == stop_q) begin
						fin = 1'b1;
						if (loc_ok_q) begin
							if (adv_q) begin
								cur_wr  = 1'b1;
								cur_sum = ABS_W'(cursor_q) + ABS_W'(loc_q);
								ra      = mk_res('0, CH_NUL, 1'b0, STAT_OK);
							end else begin
								ra = mk_res(loc_q, CH_NUL, 1'b0, STAT_OK);
							end
						end
					end else if (c == CH_NUL) begin
						fin = 1'b1;
					end else if (c == dbyte_q) begin
						loc_ok_nx = 1'b1;
						loc_nx    = rel_s1;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end
	end

	// control, text length, cursor and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			text_len_q <= '0;
			cursor_q   <= '0;
			limit_q    <= SCAN_LIMIT_RST;
			v_s1       <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) limit_q <= cfg.scan_limit;
			v_s1 <= (state_q == ST_SCAN);
			// output register loads a result or empties once taken
			if (state_q == ST_DONE && out_free) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						priority if (cmd.command == CMD_LOAD) begin
							if (text_len_q < LEN_W'(BUF_DEPTH))
								text_len_q <= text_len_q + LEN_W'(1);
						end else if (cmd.command == CMD_CLEAR) begin
							text_len_q <= '0;
							cursor_q   <= '0;
						end else if (cmd.command <= CMD_LAST_BEFORE) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (fin) begin
						state_q <= ST_DONE;
						if (cur_wr) cursor_q <= cur_new;
					end
				end
				ST_DONE: begin
					if (out_free && !two_q) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rel_s1    <= rd_rel_q;
		beyond_s1 <= (rd_abs >= ABS_W'(text_len_q));
		if (cmd_acc) begin
			cmd_q   <= cmd.command;
			dbyte_q <= cmd.data_byte;
			stop_q  <= cmd.stop_char;
			pat_q   <= cmd.pattern;
			adv_q   <= cmd.advance;
			cset_q  <= cmd.char_set;
			plen_q  <= (cmd.pattern_len == '0) ? PLEN_W'(1)
				: (cmd.pattern_len > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN)
				: cmd.pattern_len;
			csize_q <= (cmd.char_set_size == '0) ? CSIZE_W'(1)
				: (cmd.char_set_size > CSIZE_W'(SET_SIZE)) ? CSIZE_W'(SET_SIZE)
				: cmd.char_set_size;
			rep_q   <= (cmd.repeat_or_extra == '0 && cmd.command == CMD_NTH) ? OFF_W'(1)
				: cmd.repeat_or_extra;
			priority if (cmd.command == CMD_FIND_START || cmd.command == CMD_FIND_END) begin
				rd_rel_q <= REL_W'(cmd.start_offset);
			end else if (cmd.command == CMD_LAST_BEFORE) begin
				rd_rel_q <= REL_W'(1);
			end else begin
				rd_rel_q <= '0;
			end
			fill_q   <= '0;
			depth_q  <= '0;
			cnt_q    <= '0;
			first_q  <= 1'b0;
			loc_ok_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			rd_rel_q <= rd_rel_q + REL_W'(1);
			if (v_s1) begin
				for (int i = 0; i < MAX_PATTERN; i++) win_q[i] <= win_nx[i];
				if (fill_q < FILL_W'(MAX_PATTERN)) fill_q <= fill_q + FILL_W'(1);
			end
			depth_q  <= depth_nx;
			cnt_q    <= cnt_nx;
			first_q  <= first_nx;
			idx1_q   <= idx1_nx;
			loc_ok_q <= loc_ok_nx;
			loc_q    <= loc_nx;
			if (fin) begin
				res_a_q <= ra;
				res_b_q <= rb;
				two_q   <= two;
			end
		end else if (state_q == ST_DONE && out_free) begin
			// second result of first two moves up
			out_q      <= res_a_q;
			out_last_q <= !two_q;
			res_a_q    <= res_b_q;
			two_q      <= 1'b0;
		end
	end

	assign res.valid       = out_v_q;
	assign res.position    = out_q.position;
	assign res.found_char  = out_q.found_char;
	assign res.is_match    = out_q.is_match;
	assign res.status      = out_q.status;
	assign res.last_of_run = out_last_q;

	`ASSERT_ALWAYS(a_cursor_in_text, cursor_q <= ADDR_W'(text_len_q) || text_len_q[ADDR_W], "cursor past text end")
	`ASSERT_ALWAYS(a_len_bound, text_len_q <= LEN_W'(BUF_DEPTH), "text length overflow")
	`ASSERT_SAME(a_read_in_scan, v_s1, $past(state_q) == ST_SCAN, "read data outside a scan")
	`ASSERT_NEXT(a_done_hands_off, state_q == ST_DONE && out_free, out_v_q, "result not handed off")
endmodule
`default_nettype wire

/* verif/tb_text_cursor_search_engine.sv */
`timescale 1ns / 1ps
module tb_text_cursor_search_engine;
	import tcse_pkg::*;

	// request codes beyond the defined set, the block drops these
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd12;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;
	localparam int CFG_SETTLE = 12;  // quiet cycles before a limit write
	localparam int DRAIN_WAIT = 40;  // quiet cycles at the end of the run

	typedef struct {
		logic [CMD_W-1:0]         command;
		logic [7:0]               data_byte;
		logic [7:0]               stop_char;
		logic [8*MAX_PATTERN-1:0] pattern;
		logic [PLEN_W-1:0]        pattern_len;
		logic [OFF_W-1:0]         start_offset;
		logic [OFF_W-1:0]         repeat_or_extra;
		logic                     advance;
		logic [8*SET_SIZE-1:0]    char_set;
		logic [CSIZE_W-1:0]       char_set_size;
	} request_t;

	typedef struct {
		logic signed [POS_W-1:0] position;
		logic [7:0]              found_char;
		logic                    is_match;
		logic [STAT_W-1:0]       status;
		logic                    last_of_run;
	} answer_t;

	typedef struct {
		request_t req;
		bit       typed;   // expected answer given in the row itself
		answer_t  ans;
	} row_t;

	logic clk;
	logic arst_n;

	tcse_cmd_if cmd_ch ();
	tcse_res_if res_ch ();
	tcse_cfg_if cfg_ch ();

	text_cursor_search_engine u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch.sink),
		.res   (res_ch.source),
		.cfg   (cfg_ch.sink)
	);

	// mirror of the text buffer, cursor and scan limit
	logic [7:0] text_mirror [BUF_DEPTH];
	int         text_len;
	int         cursor_pos;
	int         limit_val;

	answer_t answers_due [$];   // answers still owed by the block
	answer_t fresh_answers [$]; // answers of the request just predicted
	row_t    dir_rows [$];
	int      errors;
	bit      idling_on;

	// alphabet that makes nested blocks and repeated patterns likely
	logic [7:0] alpha [8] = '{8'h61, 8'h62, 8'h78, CH_OPEN_BRACE, CH_CLOSE_BRACE,
		CH_OPEN_BRACKET, CH_CLOSE_BRACKET, 8'h61};

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop on a hung run
	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

	// ---------------- predictor ----------------

	// bytes past the text end read as zero
	function automatic int text_byte(int p);
		return (p < text_len) ? int'(text_mirror[p]) : 0;
	endfunction

	// cursor moves saturate at the text length and the last buffer slot
	function automatic void move_cursor(int v);
		if (v > text_len) v = text_len;
		if (v > BUF_DEPTH - 1) v = BUF_DEPTH - 1;
		cursor_pos = v;
	endfunction

	function automatic bit pattern_hits(int p, logic [63:0] pat, int len);
		int c;
		for (int j = 0; j < len; j++) begin
			c = text_byte(p + j);
			if (c == 0 || c != int'(pat[8*j +: 8])) return 1'b0;
		end
		return 1'b1;
	endfunction

	// brute force scan, candidate start steps by one byte
	function automatic int pattern_seek(int from, logic [63:0] pat, int len);
		for (int s = from; text_byte(cursor_pos + s) != 0; s++)
			if (pattern_hits(cursor_pos + s, pat, len)) return s;
		return -1;
	endfunction

	function automatic int distance_to_end();
		int i;
		i = 0;
		while (text_byte(cursor_pos + i) != 0) i++;
		return i;
	endfunction

	function automatic void emit(int pos, int ch, bit m, stat_t st, bit last);
		answer_t a;
		a.position    = pos[POS_W-1:0];
		a.found_char  = ch[7:0];
		a.is_match    = m;
		a.status      = st;
		a.last_of_run = last;
		fresh_answers.push_back(a);
	endfunction

	function automatic void predict_request(request_t r);
		int plen, csz, rep, idx, idx2, span, depth, loc, c, i, fate, old;
		bit m, done;
		fresh_answers.delete();
		plen = r.pattern_len;
		if (plen < 1) plen = 1;
		if (plen > MAX_PATTERN) plen = MAX_PATTERN;
		csz = r.char_set_size;
		if (csz < 1) csz = 1;
		if (csz > SET_SIZE) csz = SET_SIZE;
		if (csz > 4) csz = 4;
		old = cursor_pos;
		case (r.command)
			CMD_LOAD: begin
				// a full buffer drops the byte
				if (text_len < BUF_DEPTH) begin
					text_mirror[text_len] = r.data_byte;
					text_len++;
				end
			end
			CMD_CLEAR: begin
				text_len   = 0;
				cursor_pos = 0;
			end
			CMD_FIND_START, CMD_FIND_END: begin
				idx = pattern_seek(int'(r.start_offset), r.pattern, plen);
				if (idx >= 0 && r.command == CMD_FIND_END) idx += plen;
				emit(idx, 0, 0, idx < 0 ? STAT_NOT_FOUND : STAT_OK, 1);
			end
			CMD_NTH: begin
				// occurrence zero counts as the first
				rep = r.repeat_or_extra;
				if (rep < 1) rep = 1;
				idx = pattern_seek(0, r.pattern, plen);
				for (i = 1; i < rep && idx >= 0; i++)
					idx = pattern_seek(idx + 1, r.pattern, plen);
				emit(idx, 0, 0, idx < 0 ? STAT_NOT_FOUND : STAT_OK, 1);
			end
			CMD_FIRST_TWO: begin
				idx  = pattern_seek(0, r.pattern, plen);
				idx2 = (idx >= 0) ? pattern_seek(idx + 1, r.pattern, plen) : -1;
				emit(idx, 0, 0, idx < 0 ? STAT_NOT_FOUND : STAT_OK, 0);
				emit(idx2, 0, 0, idx2 < 0 ? STAT_NOT_FOUND : STAT_OK, 1);
			end
			CMD_GOTO_START, CMD_GOTO_END: begin
				idx = pattern_seek(0, r.pattern, plen);
				if (idx < 0) begin
					// no hit parks the cursor at the text end
					move_cursor(cursor_pos + distance_to_end());
					emit(-1, 0, 0, STAT_NOT_FOUND, 1);
				end else begin
					span = idx;
					if (r.command == CMD_GOTO_END) span += plen + int'(r.repeat_or_extra);
					move_cursor(cursor_pos + span);
					emit(cursor_pos - old, 0, 0, STAT_OK, 1);
				end
			end
			CMD_STARTS_WITH: begin
				m = pattern_hits(cursor_pos, r.pattern, plen);
				if (m && r.advance) move_cursor(cursor_pos + plen);
				emit(0, 0, m, m ? STAT_OK : STAT_NOT_FOUND, 1);
			end
			CMD_FIRST_OF: begin
				done = 1'b0;
				for (i = 0; i < limit_val && !done; i++) begin
					c = text_byte(cursor_pos + i);
					for (int k = 0; k < csz; k++) begin
						if (!done && c == int'(r.char_set[8*k +: 8])) begin
							if (r.advance) move_cursor(cursor_pos + i);
							emit(i, c, 0, STAT_OK, 1);
							done = 1'b1;
						end
					end
					if (!done && c == 0) begin
						emit(-1, 0, 0, STAT_NOT_FOUND, 1);
						done = 1'b1;
					end
				end
				if (!done) emit(limit_val, 0, 0, STAT_LIMIT, 1);
			end
			CMD_BLOCK_END: begin
				// fate: 0 scanning, 1 answered, 2 block closed at byte i
				depth = 0;
				fate  = 0;
				i     = 0;
				while (fate == 0) begin
					c = text_byte(cursor_pos + i);
					if (c == 0) begin
						emit(-1, 0, 0, STAT_NOT_FOUND, 1);
						fate = 1;
					end else if (c == int'(CH_OPEN_BRACE) || c == int'(CH_OPEN_BRACKET)) begin
						depth++;
					end else if (c == int'(CH_CLOSE_BRACE) || c == int'(CH_CLOSE_BRACKET)) begin
						if (depth == 0) begin
							emit(-1, 0, 0, STAT_UNBALANCED, 1);
							fate = 1;
						end else begin
							depth--;
							if (depth == 0) fate = 2;
						end
					end
					if (fate == 0) i++;
				end
				if (fate == 2) begin
					if (r.advance) begin
						move_cursor(cursor_pos + i + 1);
						emit(0, 0, 0, STAT_OK, 1);
					end else begin
						emit(i + 1, 0, 0, STAT_OK, 1);
					end
				end
			end
			CMD_LAST_BEFORE: begin
				// fate: 0 scanning, 1 text end first, 2 stop seen
				loc  = -1;
				fate = 0;
				i    = 1;
				while (fate == 0) begin
					c = text_byte(cursor_pos + i);
					if (c == int'(r.stop_char)) fate = 2;
					else if (c == 0) fate = 1;
					else begin
						if (c == int'(r.data_byte)) loc = i;
						i++;
					end
				end
				if (fate == 1) begin
					emit(-1, 0, 0, STAT_NOT_FOUND, 1);
				end else begin
					if (loc >= 0 && r.advance) begin
						move_cursor(cursor_pos + loc);
						loc = 0;
					end
					emit(loc, 0, 0, loc < 0 ? STAT_NOT_FOUND : STAT_OK, 1);
				end
			end
			default: begin
				// spare codes do nothing
			end
		endcase
	endfunction

	// ---------------- drivers ----------------

	// one request; valid stays high after acceptance until the next gap
	task automatic send_request(request_t r, bit typed, answer_t a);
		if (idling_on && $urandom_range(99) < 16) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_ch.valid           <= 1'b1;
		cmd_ch.command         <= r.command;
		cmd_ch.data_byte       <= r.data_byte;
		cmd_ch.stop_char       <= r.stop_char;
		cmd_ch.pattern         <= r.pattern;
		cmd_ch.pattern_len     <= r.pattern_len;
		cmd_ch.start_offset    <= r.start_offset;
		cmd_ch.repeat_or_extra <= r.repeat_or_extra;
		cmd_ch.advance         <= r.advance;
		cmd_ch.char_set        <= r.char_set;
		cmd_ch.char_set_size   <= r.char_set_size;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_request(r);
		if (typed) answers_due.push_back(a);
		else foreach (fresh_answers[n]) answers_due.push_back(fresh_answers[n]);
	endtask

	// limit writes only once the block has gone quiet
	task automatic write_scan_limit(int v);
		cmd_ch.valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.scan_limit <= v[OFF_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		limit_val = v;
	endtask

	// ---------------- stimulus builders ----------------

	function automatic request_t blank_request(logic [CMD_W-1:0] c);
		request_t r;
		r.command         = c;
		r.data_byte       = 8'h00;
		r.stop_char       = 8'h00;
		r.pattern         = '0;
		r.pattern_len     = 4'd1;
		r.start_offset    = '0;
		r.repeat_or_extra = '0;
		r.advance         = 1'b0;
		r.char_set        = '0;
		r.char_set_size   = 3'd1;
		return r;
	endfunction

	function automatic answer_t answer(int pos, int ch, bit m, stat_t st);
		answer_t a;
		a.position    = pos[POS_W-1:0];
		a.found_char  = ch[7:0];
		a.is_match    = m;
		a.status      = st;
		a.last_of_run = 1'b1;
		return a;
	endfunction

	function automatic void add_row(request_t r, bit typed, answer_t a);
		row_t w;
		w.req   = r;
		w.typed = typed;
		w.ans   = a;
		dir_rows.push_back(w);
	endfunction

	function automatic logic [7:0] pick_char();
		int t;
		t = $urandom_range(19);
		if (t == 0) return 8'h00;
		if (t < 3) return 8'($urandom);
		return alpha[$urandom_range(7)];
	endfunction

	// byte for the text; zero only rarely so texts do not end early
	function automatic logic [7:0] text_char();
		if ($urandom_range(9) == 0) return 8'($urandom);
		return alpha[$urandom_range(7)];
	endfunction

	// query with content drawn mostly from the current text
	function automatic request_t random_query();
		request_t r;
		int pl, at;
		r = blank_request(4'($urandom_range(int'(CMD_FIND_START), int'(CMD_LAST_BEFORE))));
		pl = $urandom_range(1, MAX_PATTERN);
		if ($urandom_range(3) != 0) pl = $urandom_range(1, 3);
		at = cursor_pos + $urandom_range(0, 12);
		r.pattern = {$urandom, $urandom};
		for (int j = 0; j < pl; j++)
			if ($urandom_range(7) != 0)
				r.pattern[8*j +: 8] = (at + j < text_len) ? text_mirror[at + j] : pick_char();
		r.pattern_len = ($urandom_range(9) == 0) ? 4'($urandom) : pl[PLEN_W-1:0];
		r.start_offset = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 5));
		r.repeat_or_extra = ($urandom_range(9) == 0) ? 10'($urandom)
			: 10'($urandom_range(0, 4));
		r.advance = 1'($urandom);
		r.char_set = ($urandom_range(7) == 0) ? $urandom
			: {pick_char(), pick_char(), pick_char(), pick_char()};
		r.char_set_size = 3'($urandom);
		r.data_byte = pick_char();
		r.stop_char = pick_char();
		return r;
	endfunction

	// anything at all, spare codes included
	function automatic request_t noise_request();
		request_t r;
		r.command         = 4'($urandom);
		r.data_byte       = 8'($urandom);
		r.stop_char       = 8'($urandom);
		r.pattern         = {$urandom, $urandom};
		r.pattern_len     = 4'($urandom);
		r.start_offset    = 10'($urandom);
		r.repeat_or_extra = 10'($urandom);
		r.advance         = 1'($urandom);
		r.char_set        = $urandom;
		r.char_set_size   = 3'($urandom);
		return r;
	endfunction

	// ---------------- result checker ----------------

	initial begin
		answer_t w;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (answers_due.size() == 0) begin
					$error("result with nothing expected, position %0d", res_ch.position);
					errors++;
				end else begin
					w = answers_due.pop_front();
					if (res_ch.position !== w.position) begin
						$error("position expected %0d actual %0d", w.position, res_ch.position);
						errors++;
					end
					if (res_ch.found_char !== w.found_char) begin
						$error("found_char expected %0h actual %0h", w.found_char,
							res_ch.found_char);
						errors++;
					end
					if (res_ch.is_match !== w.is_match) begin
						$error("is_match expected %0b actual %0b", w.is_match, res_ch.is_match);
						errors++;
					end
					if (res_ch.status !== w.status) begin
						$error("status expected %0d actual %0d", w.status, res_ch.status);
						errors++;
					end
					if (res_ch.last_of_run !== w.last_of_run) begin
						$error("last_of_run expected %0b actual %0b", w.last_of_run,
							res_ch.last_of_run);
						errors++;
					end
				end
			end
			// receiver stalls about one cycle in six unless idling is off
			res_ch.ready <= idling_on ? ($urandom_range(99) >= 16) : 1'b1;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		request_t r;
		answer_t  none;
		int       limits [5];
		int       n_text, n_query;
		logic [7:0] sample_text [10] = '{8'h61, 8'h62, CH_OPEN_BRACE, CH_OPEN_BRACKET, 8'h61,
			CH_CLOSE_BRACKET, CH_CLOSE_BRACE, 8'h61, 8'h62, CH_CLOSE_BRACKET};

		errors     = 0;
		idling_on  = 1'b1;
		text_len   = 0;
		cursor_pos = 0;
		limit_val  = int'(SCAN_LIMIT_RST);
		none       = answer(0, 0, 0, STAT_OK);

		// every input known from time zero
		arst_n                 = 1'b0;
		cmd_ch.valid           = 1'b0;
		cmd_ch.command         = CMD_LOAD;
		cmd_ch.data_byte       = '0;
		cmd_ch.stop_char       = '0;
		cmd_ch.pattern         = '0;
		cmd_ch.pattern_len     = '0;
		cmd_ch.start_offset    = '0;
		cmd_ch.repeat_or_extra = '0;
		cmd_ch.advance         = 1'b0;
		cmd_ch.char_set        = '0;
		cmd_ch.char_set_size   = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.scan_limit      = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		// empty text right after reset finds nothing
		r = blank_request(CMD_FIND_START);
		add_row(r, 1, answer(-1, 0, 0, STAT_NOT_FOUND));
		foreach (sample_text[k]) begin
			r = blank_request(CMD_LOAD);
			r.data_byte = sample_text[k];
			add_row(r, 0, none);
		end
		r = blank_request(CMD_FIND_START);
		r.pattern = 64'h6261; r.pattern_len = 4'd2; r.start_offset = 10'd1;
		add_row(r, 0, none);
		// pattern length zero acts as one
		r = blank_request(CMD_FIND_END);
		r.pattern = 64'h62; r.pattern_len = 4'd0;
		add_row(r, 0, none);
		// occurrence zero acts as the first
		r = blank_request(CMD_NTH);
		r.pattern = 64'h61; r.repeat_or_extra = 10'd0;
		add_row(r, 0, none);
		r = blank_request(CMD_FIRST_TWO);
		r.pattern = 64'h6261; r.pattern_len = 4'd2;
		add_row(r, 0, none);
		// length above the maximum saturates at eight
		r = blank_request(CMD_STARTS_WITH);
		r.pattern = 64'hFFFF_FFFF_FFFF_6261; r.pattern_len = 4'd15; r.advance = 1'b1;
		add_row(r, 0, none);
		r = blank_request(CMD_STARTS_WITH);
		r.pattern = 64'h6261; r.pattern_len = 4'd2; r.advance = 1'b1;
		add_row(r, 0, none);
		// set size zero acts as one
		r = blank_request(CMD_FIRST_OF);
		r.char_set = {8'h61, 8'h00, 8'h5B, CH_CLOSE_BRACE}; r.char_set_size = 3'd0;
		add_row(r, 0, none);
		r = blank_request(CMD_BLOCK_END);
		add_row(r, 0, none);
		r = blank_request(CMD_LAST_BEFORE);
		r.data_byte = 8'h61; r.stop_char = CH_CLOSE_BRACKET; r.advance = 1'b1;
		add_row(r, 0, none);
		r = blank_request(CMD_GOTO_START);
		r.pattern = 64'h7B;
		add_row(r, 0, none);
		r = blank_request(CMD_BLOCK_END);
		r.advance = 1'b1;
		add_row(r, 0, none);
		// goto end with the largest extra advance saturates at the text end
		r = blank_request(CMD_GOTO_END);
		r.pattern = 64'h62; r.repeat_or_extra = 10'h3FF;
		add_row(r, 0, none);
		add_row(blank_request(CMD_SPARE_LO), 0, none);
		add_row(blank_request(CMD_SPARE_HI), 0, none);
		add_row(blank_request(CMD_CLEAR), 0, none);
		// goto on an empty text: cursor stays, not found
		r = blank_request(CMD_GOTO_END);
		add_row(r, 1, answer(-1, 0, 0, STAT_NOT_FOUND));
		r = blank_request(CMD_LOAD);
		r.data_byte = CH_CLOSE_BRACE;
		add_row(r, 0, none);
		// close at depth zero
		add_row(blank_request(CMD_BLOCK_END), 1, answer(-1, 0, 0, STAT_UNBALANCED));
		// set size above four saturates, close brace found at the cursor
		r = blank_request(CMD_FIRST_OF);
		r.char_set = {CH_CLOSE_BRACE, 8'h01, 8'h02, 8'h03}; r.char_set_size = 3'd7;
		add_row(r, 1, answer(0, int'(CH_CLOSE_BRACE), 0, STAT_OK));
		foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed,
			dir_rows[k].ans);

		// random phases over several scan limits, extremes included
		limits = '{1, 1023, int'(SCAN_LIMIT_RST), $urandom_range(2, 40), $urandom_range(1, 1023)};
		for (int ph = 0; ph < 5; ph++) begin
			write_scan_limit(limits[ph]);
			idling_on = (ph != 2);  // one long stretch with no idling
			for (int cnt = 0; cnt < 145; ) begin
				if ($urandom_range(99) < 85) begin
					// well formed: fresh text, then a run of queries on it
					send_request(blank_request(CMD_CLEAR), 0, none);
					n_text = $urandom_range(1, 40);
					for (int k = 0; k < n_text; k++) begin
						r = blank_request(CMD_LOAD);
						r.data_byte = text_char();
						send_request(r, 0, none);
					end
					n_query = $urandom_range(3, 8);
					for (int k = 0; k < n_query; k++) send_request(random_query(), 0, none);
					cnt += 1 + n_text + n_query;
				end else begin
					send_request(noise_request(), 0, none);
					cnt++;
				end
			end
		end
		idling_on = 1'b1;

		// drain
		cmd_ch.valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
